### rtl/dpe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the DPI edge pruning block.
// Depends on nothing; used by dpi_edge_pruning and the testbench.
package dpe_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int MI_W          = 16;
   localparam int FRAC_W        = 12;
   localparam int IDX_W         = 6;
   localparam int CNT_W         = 11;
   localparam int NCFG_W        = 7;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int PROD_W        = 2 * MI_W;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // request codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_RUN    = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DPI_EN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TF_EN      = 3'd4;

   localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 7'd64;
   localparam logic [MI_W-1:0]   GAIN_RST       = 16'd4096;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
      logic [MI_W-1:0]  mi_value;
      logic             node_is_tf;
   } dpe_req_type;

   typedef struct packed {
      logic [MI_W-1:0]  read_value;
      logic [CNT_W-1:0] edge_count;
      logic             status;
   } dpe_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_TH_RD,
      ST_TH_WR,
      ST_MK_EDGE_RD,
      ST_MK_EDGE_CHK,
      ST_MK_Y_RD,
      ST_MK_Y_CHK,
      ST_CL_RD,
      ST_CL_WR,
      ST_DONE
   } dpe_state_type;

endpackage

### rtl/dpe_ram.sv
`timescale 1ns / 1ps
// Synchronous RAM: one write port, two read ports with registered data.
// Depends on nothing.
module dpe_ram #(
   parameter int AW    = 12,
   parameter int DW    = 17,
   parameter int DEPTH = 4096
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_a_addr,
   output logic [DW-1:0] rd_a_data,
   input  logic [AW-1:0] rd_b_addr,
   output logic [DW-1:0] rd_b_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

### rtl/dpi_edge_pruning.sv
`timescale 1ns / 1ps
// Top level of the DPI edge pruning block: request handling, run sequencer.
// Depends on dpe_pkg and dpe_ram.
//
//   channel  | ports                         | moves
//   ---------+-------------------------------+-------------------------------
//   request  | req_valid, req_stall, req_data| load, run or read request
//   response | rsp_valid, rsp_stall, rsp_data| one response per request
//   config   | csr_wr_en, csr_index, csr_wdata| register write, no read-back
//
// A load, an out-of-range read or an unused code answers in the cycle after
// acceptance; a valid read answers from ST_RD_WAIT after the matrix RAM read.
// A run walks the RAM: a threshold pass rewrites all n*n entries, a
// marking pass (dpi_en set) tries witnesses y (at most n) per nonzero upper
// edge, and a last pass clears and counts; the RAM port sets the pace.
// Reset is synchronous and clears control state and registers only; the
// matrix and flags stay undefined until loaded, no clearing pass.
// One request is in flight at a time; req_stall is high while a request is
// at work or a response waits to be taken.
module dpi_edge_pruning #(
   parameter int MAX_NODES = dpe_pkg::MAX_NODES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dpe_pkg::dpe_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dpe_pkg::dpe_rsp_type                rsp_data,
   input  logic                                csr_wr_en,
   input  logic [dpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NW    = $clog2(MAX_NODES);
   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int AW    = 2 * NW;
   localparam int DEPTH = 1 << AW;
   localparam int MW    = dpe_pkg::MI_W + 1;
   localparam int MI_W  = dpe_pkg::MI_W;

   dpe_pkg::dpe_state_type state_ff, state_in;

   // configuration
   logic [dpe_pkg::NCFG_W-1:0] node_count_ff;
   logic [MI_W-1:0]            threshold_ff;
   logic [MI_W-1:0]            gain_ff;
   logic                       dpi_en_ff;
   logic                       tf_en_ff;

   // sequencer
   logic [CW-1:0]               x_ff, z_ff, y_ff;
   logic [MI_W-1:0]             axz_ff;
   logic                        one_tf_ff;
   logic [dpe_pkg::PROD_W-1:0]  bound_ff;
   logic [dpe_pkg::CNT_W-1:0]   count_ff;
   logic [dpe_pkg::CNT_W-1:0]   edge_total_ff;
   logic                        rsp_valid_ff;
   dpe_pkg::dpe_rsp_type        rsp_data_ff;

   // RAM ports
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_ra_addr, mem_rb_addr;
   logic [MW-1:0] mem_wdata, mem_ra_data, mem_rb_data;
   logic          flg_we;
   logic [NW-1:0] flg_waddr, flg_ra_addr, flg_rb_addr;
   logic [0:0]    flg_wdata, flg_ra_data, flg_rb_data;

   logic [CW-1:0] n_eff, z_next1, x_next1, x_next2, y_next1, edge_x_nxt, edge_z_nxt;
   logic          req_fire, rsp_fire, req_oob, row_last, tri_last, witness, n_ge2;
   logic [AW-1:0] req_addr, addr_xz, addr_xy, addr_zy;

   dpe_ram #(.AW(AW), .DW(MW), .DEPTH(DEPTH)) u_matrix (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_a_addr (mem_ra_addr),
      .rd_a_data (mem_ra_data),
      .rd_b_addr (mem_rb_addr),
      .rd_b_data (mem_rb_data)
   );

   dpe_ram #(.AW(NW), .DW(1), .DEPTH(MAX_NODES)) u_flags (
      .clock     (clock),
      .wr_en     (flg_we),
      .wr_addr   (flg_waddr),
      .wr_data   (flg_wdata),
      .rd_a_addr (flg_ra_addr),
      .rd_a_data (flg_ra_data),
      .rd_b_addr (flg_rb_addr),
      .rd_b_data (flg_rb_data)
   );

   // node count clipped to the matrix size
   assign n_eff = (32'(node_count_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_ff);
   assign n_ge2 = (32'(n_eff) >= 32'd2);

   assign req_stall = !((state_ff == dpe_pkg::ST_IDLE) && !rsp_valid_ff);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_oob = (32'(req_data.row_index) >= 32'(n_eff))
                 || (32'(req_data.col_index) >= 32'(n_eff));
   assign req_addr = {NW'(req_data.row_index), NW'(req_data.col_index)};
   assign addr_xz  = {x_ff[NW-1:0], z_ff[NW-1:0]};
   assign addr_xy  = {x_ff[NW-1:0], y_ff[NW-1:0]};
   assign addr_zy  = {z_ff[NW-1:0], y_ff[NW-1:0]};

   assign z_next1  = CW'(z_ff + 1'b1);
   assign x_next1  = CW'(x_ff + 1'b1);
   assign x_next2  = CW'(x_ff + 2'd2);
   assign y_next1  = CW'(y_ff + 1'b1);
   assign row_last = (z_next1 == n_eff);
   assign tri_last = row_last && (x_next2 == n_eff);

   // step to the next upper-triangle edge, wrapping to (0,1) after the last
   always_comb begin
      if (tri_last) begin
         edge_x_nxt = '0;
         edge_z_nxt = CW'(1);
      end else if (row_last) begin
         edge_x_nxt = x_next1;
         edge_z_nxt = x_next2;
      end else begin
         edge_x_nxt = x_ff;
         edge_z_nxt = z_next1;
      end
   end

   // witness y holds when both sides reach the scaled edge, unless the
   // factor rule drops it
   assign witness =
      (dpe_pkg::PROD_W'({mem_ra_data[MI_W-1:0], {dpe_pkg::FRAC_W{1'b0}}}) >= bound_ff)
      && (dpe_pkg::PROD_W'({mem_rb_data[MI_W-1:0], {dpe_pkg::FRAC_W{1'b0}}}) >= bound_ff)
      && !(tf_en_ff && !flg_ra_data[0] && one_tf_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpe_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.req_type == dpe_pkg::REQ_RUN) begin
                  state_in = (n_eff == '0) ? dpe_pkg::ST_DONE : dpe_pkg::ST_TH_RD;
               end else if (req_data.req_type == dpe_pkg::REQ_READ && !req_oob) begin
                  state_in = dpe_pkg::ST_RD_WAIT;
               end
            end
         end
         dpe_pkg::ST_RD_WAIT: state_in = dpe_pkg::ST_IDLE;
         dpe_pkg::ST_TH_RD:   state_in = dpe_pkg::ST_TH_WR;
         dpe_pkg::ST_TH_WR: begin
            if (row_last && x_next1 == n_eff) begin
               if (!n_ge2) begin
                  state_in = dpe_pkg::ST_DONE;
               end else if (dpi_en_ff) begin
                  state_in = dpe_pkg::ST_MK_EDGE_RD;
               end else begin
                  state_in = dpe_pkg::ST_CL_RD;
               end
            end else begin
               state_in = dpe_pkg::ST_TH_RD;
            end
         end
         dpe_pkg::ST_MK_EDGE_RD: state_in = dpe_pkg::ST_MK_EDGE_CHK;
         dpe_pkg::ST_MK_EDGE_CHK: begin
            if (mem_ra_data[MI_W-1:0] != '0) begin
               state_in = dpe_pkg::ST_MK_Y_RD;
            end else begin
               state_in = tri_last ? dpe_pkg::ST_CL_RD : dpe_pkg::ST_MK_EDGE_RD;
            end
         end
         dpe_pkg::ST_MK_Y_RD: state_in = dpe_pkg::ST_MK_Y_CHK;
         dpe_pkg::ST_MK_Y_CHK: begin
            if (witness || y_next1 == n_eff) begin
               state_in = tri_last ? dpe_pkg::ST_CL_RD : dpe_pkg::ST_MK_EDGE_RD;
            end else begin
               state_in = dpe_pkg::ST_MK_Y_RD;
            end
         end
         dpe_pkg::ST_CL_RD: state_in = dpe_pkg::ST_CL_WR;
         dpe_pkg::ST_CL_WR: state_in = tri_last ? dpe_pkg::ST_DONE : dpe_pkg::ST_CL_RD;
         dpe_pkg::ST_DONE:  state_in = dpe_pkg::ST_IDLE;
         default:           state_in = dpe_pkg::ST_IDLE;
      endcase
   end

   // RAM controls; bit MI_W of a matrix word is the prune mark
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = addr_xz;
      mem_wdata   = '0;
      mem_ra_addr = addr_xz;
      mem_rb_addr = addr_zy;
      flg_we      = 1'b0;
      flg_waddr   = NW'(req_data.row_index);
      flg_wdata   = req_data.node_is_tf;
      flg_ra_addr = x_ff[NW-1:0];
      flg_rb_addr = z_ff[NW-1:0];
      unique case (state_ff)
         dpe_pkg::ST_IDLE: begin
            mem_ra_addr = req_addr;
            mem_waddr   = req_addr;
            mem_wdata   = {1'b0, req_data.mi_value};
            mem_we      = req_fire && (req_data.req_type == dpe_pkg::REQ_LOAD) && !req_oob;
            flg_we      = mem_we && (req_data.col_index == '0);
         end
         dpe_pkg::ST_TH_WR: begin
            // rewrite every entry: drop values under threshold, clear the mark
            mem_we = 1'b1;
            if (mem_ra_data[MI_W-1:0] >= threshold_ff) begin
               mem_wdata = {1'b0, mem_ra_data[MI_W-1:0]};
            end
         end
         dpe_pkg::ST_MK_Y_RD: begin
            mem_ra_addr = addr_xy;
            flg_ra_addr = y_ff[NW-1:0];
         end
         dpe_pkg::ST_MK_Y_CHK: begin
            mem_we    = witness;
            mem_wdata = {1'b1, axz_ff};
         end
         dpe_pkg::ST_CL_WR: begin
            mem_we = mem_ra_data[MI_W];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dpe_pkg::ST_IDLE;
         node_count_ff <= dpe_pkg::NODE_COUNT_RST;
         threshold_ff  <= '0;
         gain_ff       <= dpe_pkg::GAIN_RST;
         dpi_en_ff     <= 1'b1;
         tf_en_ff      <= 1'b0;
         x_ff          <= '0;
         z_ff          <= '0;
         y_ff          <= '0;
         count_ff      <= '0;
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_index)
               dpe_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wdata[dpe_pkg::NCFG_W-1:0];
               dpe_pkg::CSR_THRESHOLD:  threshold_ff  <= csr_wdata[MI_W-1:0];
               dpe_pkg::CSR_GAIN:       gain_ff       <= csr_wdata[MI_W-1:0];
               dpe_pkg::CSR_DPI_EN:     dpi_en_ff     <= csr_wdata[0];
               dpe_pkg::CSR_TF_EN:      tf_en_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end

         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            dpe_pkg::ST_IDLE: begin
               if (req_fire) begin
                  if (req_data.req_type == dpe_pkg::REQ_RUN) begin
                     x_ff     <= '0;
                     z_ff     <= '0;
                     count_ff <= '0;
                  end else if (!(req_data.req_type == dpe_pkg::REQ_READ && !req_oob)) begin
                     // answer loads, bad reads and unused codes at once
                     rsp_valid_ff           <= 1'b1;
                     rsp_data_ff.read_value <= '0;
                     rsp_data_ff.edge_count <= edge_total_ff;
                     rsp_data_ff.status     <= req_oob
                        && (req_data.req_type == dpe_pkg::REQ_LOAD
                            || req_data.req_type == dpe_pkg::REQ_READ);
                  end
               end
            end
            dpe_pkg::ST_RD_WAIT: begin
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.read_value <= mem_ra_data[MI_W-1:0];
               rsp_data_ff.edge_count <= edge_total_ff;
               rsp_data_ff.status     <= 1'b0;
            end
            dpe_pkg::ST_TH_WR: begin
               if (row_last && x_next1 == n_eff) begin
                  x_ff <= '0;
                  z_ff <= CW'(1);
               end else if (row_last) begin
                  x_ff <= x_next1;
                  z_ff <= '0;
               end else begin
                  z_ff <= z_next1;
               end
            end
            dpe_pkg::ST_MK_EDGE_CHK: begin
               axz_ff    <= mem_ra_data[MI_W-1:0];
               one_tf_ff <= flg_ra_data[0] ^ flg_rb_data[0];
               bound_ff  <= dpe_pkg::PROD_W'(mem_ra_data[MI_W-1:0])
                          * dpe_pkg::PROD_W'(gain_ff);
               y_ff      <= '0;
               if (mem_ra_data[MI_W-1:0] == '0) begin
                  x_ff <= edge_x_nxt;
                  z_ff <= edge_z_nxt;
               end
            end
            dpe_pkg::ST_MK_Y_CHK: begin
               if (witness || y_next1 == n_eff) begin
                  x_ff <= edge_x_nxt;
                  z_ff <= edge_z_nxt;
               end else begin
                  y_ff <= y_next1;
               end
            end
            dpe_pkg::ST_CL_WR: begin
               if (!mem_ra_data[MI_W] && mem_ra_data[MI_W-1:0] != '0
                   && count_ff != dpe_pkg::COUNT_MAX) begin
                  count_ff <= count_ff + 1'b1;
               end
               x_ff <= edge_x_nxt;
               z_ff <= edge_z_nxt;
            end
            dpe_pkg::ST_DONE: begin
               edge_total_ff          <= count_ff;
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.read_value <= '0;
               rsp_data_ff.edge_count <= count_ff;
               rsp_data_ff.status     <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for dpi_edge_pruning: loads, runs and reads checked
// against an in-bench model of the matrix, flags and pruning pass.
// Depends on dpe_pkg and the rtl of dpi_edge_pruning.
module testbench;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   dpe_pkg::dpe_req_type           req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   dpe_pkg::dpe_rsp_type           rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [dpe_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dpe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   dpi_edge_pruning DUT (.*);

   always #5 clock = ~clock;

   // model state: matrix, factor flags and registers
   logic [dpe_pkg::MI_W-1:0]   mi_store [64*64];
   logic                       tf_store [64];
   logic [dpe_pkg::CNT_W-1:0]  edge_total_m = '0;
   logic [dpe_pkg::NCFG_W-1:0] node_cnt_m   = dpe_pkg::NODE_COUNT_RST;
   logic [dpe_pkg::MI_W-1:0]   thresh_m     = '0;
   logic [dpe_pkg::MI_W-1:0]   gain_m       = dpe_pkg::GAIN_RST;
   logic                       dpi_en_m     = 1'b1;
   logic                       tf_en_m      = 1'b0;

   dpe_pkg::dpe_req_type pending_reqs [$];
   dpe_pkg::dpe_rsp_type expected_rsps [$];
   bit          on_port = 0;   // a request sits on the port, not yet taken
   bit          quiet = 0;     // suppress idling and stalling on both sides
   int          fail_count = 0;

   function automatic int nodes_used();
      return (node_cnt_m > 64) ? 64 : int'(node_cnt_m);
   endfunction

   function automatic bit witness_found(int n, int x, int z);
      logic [31:0] bound, xy, zy;
      bit one_tf;
      bound  = mi_store[x*64+z] * gain_m;
      one_tf = tf_store[x] != tf_store[z];
      for (int y = 0; y < n; y++) begin
         xy = {4'd0, mi_store[x*64+y], 12'd0};
         zy = {4'd0, mi_store[z*64+y], 12'd0};
         if (xy < bound || zy < bound) continue;
         if (tf_en_m && !tf_store[y] && one_tf) continue;
         return 1;
      end
      return 0;
   endfunction

   task automatic prune_matrix();
      int  n, cnt;
      bit  marks [64*64];
      n = nodes_used();
      cnt = 0;
      for (int i = 0; i < 64*64; i++) marks[i] = 0;
      for (int x = 0; x < n; x++)
         for (int z = 0; z < n; z++)
            if (mi_store[x*64+z] < thresh_m) mi_store[x*64+z] = '0;
      // decide every mark before clearing any edge
      if (dpi_en_m) begin
         for (int x = 0; x + 1 < n; x++)
            for (int z = x + 1; z < n; z++)
               if (mi_store[x*64+z] != 0 && witness_found(n, x, z)) marks[x*64+z] = 1;
         for (int x = 0; x + 1 < n; x++)
            for (int z = x + 1; z < n; z++)
               if (marks[x*64+z]) mi_store[x*64+z] = '0;
      end
      for (int x = 0; x + 1 < n; x++)
         for (int z = x + 1; z < n; z++)
            if (mi_store[x*64+z] != 0 && cnt < 2047) cnt++;
      edge_total_m = dpe_pkg::CNT_W'(cnt);
   endtask

   task automatic apply_request(input dpe_pkg::dpe_req_type r,
                                output dpe_pkg::dpe_rsp_type p);
      int n;
      n = nodes_used();
      p = '0;
      if (r.req_type == dpe_pkg::REQ_LOAD || r.req_type == dpe_pkg::REQ_READ) begin
         if (r.row_index >= n || r.col_index >= n) p.status = 1'b1;
         else if (r.req_type == dpe_pkg::REQ_LOAD) begin
            mi_store[r.row_index*64 + r.col_index] = r.mi_value;
            if (r.col_index == 0) tf_store[r.row_index] = r.node_is_tf;
         end else p.read_value = mi_store[r.row_index*64 + r.col_index];
      end else if (r.req_type == dpe_pkg::REQ_RUN) prune_matrix();
      p.edge_count = edge_total_m;
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   // take the request on acceptance and work out its response
   always @(posedge clock) begin
      dpe_pkg::dpe_rsp_type p;
      if (!reset && req_valid && !req_stall) begin
         apply_request(req_data, p);
         expected_rsps = {expected_rsps, p};
         on_port = 0;
      end
   end

   // drive requests on the falling edge; hold a request until it is taken
   always @(negedge clock) begin
      if (!reset && !on_port) begin
         if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            on_port = 1;
         end else req_valid <= 1'b0;
      end
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 27);
   end

   // check each taken response against the oldest expectation
   always @(posedge clock) begin
      dpe_pkg::dpe_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with none expected", $realtime);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.read_value != e.read_value)
               report_mismatch("read_value", rsp_data.read_value, e.read_value);
            if (rsp_data.edge_count != e.edge_count)
               report_mismatch("edge_count", rsp_data.edge_count, e.edge_count);
            if (rsp_data.status != e.status)
               report_mismatch("status", rsp_data.status, e.status);
         end
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || on_port || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dpe_pkg::CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= dpe_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         dpe_pkg::CSR_NODE_COUNT: node_cnt_m = dpe_pkg::NCFG_W'(val);
         dpe_pkg::CSR_THRESHOLD:  thresh_m   = dpe_pkg::MI_W'(val);
         dpe_pkg::CSR_GAIN:       gain_m     = dpe_pkg::MI_W'(val);
         dpe_pkg::CSR_DPI_EN:     dpi_en_m   = val[0];
         dpe_pkg::CSR_TF_EN:      tf_en_m    = val[0];
         default: ;
      endcase
   endtask

   task automatic setup(int nc, int th, int gn, int de, int te);
      write_reg(dpe_pkg::CSR_NODE_COUNT, nc);
      write_reg(dpe_pkg::CSR_THRESHOLD, th);
      write_reg(dpe_pkg::CSR_GAIN, gn);
      write_reg(dpe_pkg::CSR_DPI_EN, de);
      write_reg(dpe_pkg::CSR_TF_EN, te);
   endtask

   function automatic logic [dpe_pkg::MI_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return dpe_pkg::MI_W'($urandom_range(0, 4096));
         default: return dpe_pkg::MI_W'($urandom);
      endcase
   endfunction

   task automatic queue_req(logic [1:0] t, int r, int c, logic [dpe_pkg::MI_W-1:0] v,
                            logic f);
      dpe_pkg::dpe_req_type q;
      q.req_type = t;
      q.row_index = dpe_pkg::IDX_W'(r);
      q.col_index = dpe_pkg::IDX_W'(c);
      q.mi_value = v;
      q.node_is_tf = f;
      pending_reqs = {pending_reqs, q};
   endtask

   // write every in-use entry so that no run or read touches unwritten data
   task automatic fill_matrix();
      int n;
      n = nodes_used();
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            queue_req(dpe_pkg::REQ_LOAD, r, c, pick_value(), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_mix(int count, int run_pct);
      int n, k;
      n = nodes_used();
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < run_pct)
            queue_req(dpe_pkg::REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      pick_value(), 1'($urandom_range(0, 1)));
         else if (k < 12)
            queue_req(dpe_pkg::REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                      pick_value(), 1'($urandom_range(0, 1)));
         else if (k < 22 || n == 0)
            // stray index: at or beyond the node count, either type
            queue_req($urandom_range(0, 1) ? dpe_pkg::REQ_LOAD : dpe_pkg::REQ_READ,
                      $urandom_range(n, 63), $urandom_range(0, 63), pick_value(),
                      1'($urandom_range(0, 1)));
         else if (k < 60)
            queue_req(dpe_pkg::REQ_LOAD, $urandom_range(0, n-1),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, n-1),
                      pick_value(), 1'($urandom_range(0, 1)));
         else queue_req(dpe_pkg::REQ_READ, $urandom_range(0, n-1), $urandom_range(0, n-1),
                        '0, 1'b0);
      end
   endtask

   initial begin
      int ncs [10] = '{2, 3, 5, 8, 6, 4, 0, 1, 2, 7};
      for (int i = 0; i < 64*64; i++) mi_store[i] = '0;
      for (int i = 0; i < 64; i++) tf_store[i] = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: small matrix with a pruned triangle, extremes and stray indexes
      setup(4, 0, 4096, 1, 0);
      queue_req(dpe_pkg::REQ_LOAD, 0, 0, 16'hFFFF, 1'b1);
      queue_req(dpe_pkg::REQ_LOAD, 0, 1, 16'd100, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 0, 2, 16'd300, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 0, 3, 16'd0, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 1, 0, 16'd100, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 1, 1, 16'hFFFF, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 1, 2, 16'd300, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 1, 3, 16'd50, 1'b1);
      for (int c = 0; c < 4; c++) queue_req(dpe_pkg::REQ_LOAD, 2, c, 16'd300, c == 0);
      for (int c = 0; c < 4; c++) queue_req(dpe_pkg::REQ_LOAD, 3, c, 16'd1, 1'b1);
      queue_req(dpe_pkg::REQ_LOAD, 4, 0, 16'h1234, 1'b1);
      queue_req(dpe_pkg::REQ_READ, 0, 63, '0, 1'b0);
      queue_req(dpe_pkg::REQ_UNUSED, 63, 63, 16'hFFFF, 1'b1);
      queue_req(dpe_pkg::REQ_READ, 0, 1, '0, 1'b0);
      queue_req(dpe_pkg::REQ_RUN, 0, 0, '0, 1'b0);
      queue_req(dpe_pkg::REQ_READ, 0, 1, '0, 1'b0);
      queue_req(dpe_pkg::REQ_READ, 3, 3, '0, 1'b0);
      wait_idle();
      setup(4, 0, 4096, 1, 1);
      queue_req(dpe_pkg::REQ_RUN, 0, 0, '0, 1'b0);
      wait_idle();

      // random phases over small sizes and varied settings
      for (int ph = 0; ph < 10; ph++) begin
         quiet = (ph == 3);
         setup(ncs[ph],
               (ph % 4 == 0) ? 0 : (ph == 5) ? 65535 : $urandom_range(0, 8192),
               (ph == 2) ? 65535 : (ph % 3 == 0) ? 4096 : $urandom_range(4096, 12000),
               (ph == 4) ? 0 : 1, ph % 2);
         fill_matrix();
         random_mix(100, 8);
         wait_idle();
      end
      quiet = 0;

      // node count past the array depth: indexes up to 63 are all in range
      setup(127, 0, 20000, 1, 0);
      queue_req(dpe_pkg::REQ_LOAD, 63, 63, 16'h0ABC, 1'b0);
      queue_req(dpe_pkg::REQ_LOAD, 63, 0, 16'h1234, 1'b1);
      queue_req(dpe_pkg::REQ_READ, 63, 63, '0, 1'b0);
      queue_req(dpe_pkg::REQ_READ, 63, 0, '0, 1'b0);
      queue_req(dpe_pkg::REQ_UNUSED, 63, 63, 16'hFFFF, 1'b1);
      wait_idle();
      repeat (20) @(posedge clock);

      if (fail_count == 0) $display("dpi_edge_pruning test passed");
      else $display("dpi_edge_pruning test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("dpi_edge_pruning test failed");
      $finish;
   end

endmodule
